### rtl/lpsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types and constants of the page sharer directory.
// ----------------------------------------------------------------------------
package lpsd_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int NUM_UNITS   = 16;
  localparam int PAGE_SHIFT  = 12;

  localparam int ADDR_W  = 48;
  localparam int CU_W    = 4;
  localparam int CFG_W   = 6;
  localparam int TAG_W   = ADDR_W - PAGE_SHIFT;
  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int RANK_W  = IDX_W;
  localparam int OCC_W   = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W   = (CFG_W > OCC_W) ? CFG_W : OCC_W;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(32);

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_UPDATE = 1'b1
  } lpsd_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_COMMIT
  } lpsd_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture a new transaction
    logic match;   // run the tag compare and register its results
    logic commit;  // write the table and present the result
  } lpsd_ctl_t;

  // One-hot sharer bit of a unit; an out-of-range unit sets nothing.
  function automatic logic [NUM_UNITS-1:0] unit_bit(input logic [CU_W-1:0] cu);
    logic [NUM_UNITS-1:0] b;
    b = '0;
    if (int'(cu) < NUM_UNITS) begin
      b[cu] = 1'b1;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

### rtl/lru_page_sharer_directory.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_sharer_directory
// Fully associative page directory in LRU order with per-page sharer masks.
// ----------------------------------------------------------------------------
// A transaction is captured when accepted and compared in MATCH; its result
//   is shown with done_o high in the following COMMIT state, for exactly
//   one cycle. The next transaction can be taken while a result is shown;
//   busy is high for the single compare cycle.
// Reset (rst_ni low, asynchronous): table empty, table_size back to 32.
// The receiver cannot stall: each result is valid for its done_o cycle only.
// ----------------------------------------------------------------------------
module lru_page_sharer_directory (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration: table_size register.
  input  wire logic                            cfg_we_i,
  input  wire logic [lpsd_pkg::CFG_W-1:0]      cfg_wdata_i,
  // Request.
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            cmd_i,
  input  wire logic [lpsd_pkg::ADDR_W-1:0]     virt_addr_i,
  input  wire logic [lpsd_pkg::CU_W-1:0]       cu_index_i,
  // Result.
  output logic                                 done_o,
  output logic                                 hit_o,
  output logic [lpsd_pkg::NUM_UNITS-1:0]       sharer_mask_o,
  output logic                                 evicted_o
);
  import lpsd_pkg::*;

  lpsd_ctl_t ctl;

  // Controller: IDLE -> MATCH (busy) -> COMMIT (result out, may accept).
  lpsd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctl_o  (ctl)
  );

  // Datapath: compare every valid tag in parallel during MATCH, register the
  // hit entry and the LRU victim or first free slot, then apply the table
  // write in COMMIT while the registered result sits on the output ports.
  lpsd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd_i),
    .virt_addr_i   (virt_addr_i),
    .cu_index_i    (cu_index_i),
    .hit_o         (hit_o),
    .sharer_mask_o (sharer_mask_o),
    .evicted_o     (evicted_o)
  );

  // The result strobe is the commit cycle.
  assign done_o = ctl.commit;

endmodule
`default_nettype wire

### rtl/lpsd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpsd_ctrl
// Sequencer: accept, compare, then commit and present the result.
// ----------------------------------------------------------------------------
module lpsd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  output lpsd_pkg::lpsd_ctl_t    ctl_o
);
  import lpsd_pkg::*;

  lpsd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    busy         = 1'b0;
    ctl_o.load   = 1'b0;
    ctl_o.match  = 1'b0;
    ctl_o.commit = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = ST_MATCH;
        end
      end
      ST_MATCH: begin
        busy        = 1'b1;
        ctl_o.match = 1'b1;
        state_d     = ST_COMMIT;
      end
      ST_COMMIT: begin
        // Take the next transaction while this one retires.
        ctl_o.commit = 1'b1;
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = ST_MATCH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/lpsd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpsd_dp
// Tag, sharer and recency storage with parallel compare and commit logic.
// ----------------------------------------------------------------------------
module lpsd_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lpsd_pkg::lpsd_ctl_t             ctl_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [lpsd_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                            cmd_i,
  input  wire logic [lpsd_pkg::ADDR_W-1:0]     virt_addr_i,
  input  wire logic [lpsd_pkg::CU_W-1:0]       cu_index_i,
  output logic                                 hit_o,
  output logic [lpsd_pkg::NUM_UNITS-1:0]       sharer_mask_o,
  output logic                                 evicted_o
);
  import lpsd_pkg::*;

  // Configuration.
  logic [CFG_W-1:0] table_size_q;

  // Captured transaction.
  logic             cmd_q;
  logic [TAG_W-1:0] page_q;
  logic [CU_W-1:0]  cu_q;

  // Table.
  logic [TAG_W-1:0]     tag_q    [MAX_ENTRIES];
  logic [NUM_UNITS-1:0] sharer_q [MAX_ENTRIES];
  logic [RANK_W-1:0]    rank_q   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [OCC_W-1:0]     occ_q;

  // Compare results.
  logic [MAX_ENTRIES-1:0] match_q, slot_q;
  logic                   hit_q, evict_q;
  logic [RANK_W-1:0]      frank_q;
  logic [NUM_UNITS-1:0]   mask_q;

  logic [MAX_ENTRIES-1:0] match_v, lru_v, free_v;
  logic [RANK_W-1:0]      frank_v;
  logic [NUM_UNITS-1:0]   fmask_v;
  logic [OCC_W-1:0]       occ_m1;
  logic [CMP_W-1:0]       ts_ext, lim;
  logic                   evict_v;
  logic [NUM_UNITS-1:0]   ubit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RST;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_i;
      page_q <= virt_addr_i[ADDR_W-1:PAGE_SHIFT];
      cu_q   <= cu_index_i;
    end
  end

  // Effective limit: clamp into 1..MAX_ENTRIES.
  always_comb begin
    ts_ext = CMP_W'(table_size_q);
    if (ts_ext == '0) begin
      lim = CMP_W'(1);
    end else if (ts_ext > CMP_W'(MAX_ENTRIES)) begin
      lim = CMP_W'(MAX_ENTRIES);
    end else begin
      lim = ts_ext;
    end
  end

  assign occ_m1  = occ_q - OCC_W'(1);
  assign evict_v = CMP_W'(occ_q) >= lim;
  assign free_v  = ~valid_q & (valid_q + MAX_ENTRIES'(1));

  always_comb begin
    frank_v = '0;
    fmask_v = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_v[i] = valid_q[i] && (tag_q[i] == page_q);
      lru_v[i]   = valid_q[i] && (OCC_W'(rank_q[i]) == occ_m1);
      frank_v    = frank_v | (match_v[i] ? rank_q[i] : '0);
      fmask_v    = fmask_v | (match_v[i] ? sharer_q[i] : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.match) begin
      match_q <= match_v;
      hit_q   <= |match_v;
      frank_q <= frank_v;
      mask_q  <= ((cmd_q == CMD_LOOKUP) && (|match_v)) ? fmask_v : '0;
      evict_q <= (cmd_q == CMD_UPDATE) && !(|match_v) && evict_v;
      slot_q  <= evict_v ? lru_v : free_v;
    end
  end

  assign ubit = unit_bit(cu_q);

  // Commit: lookup hit promotes, update hit adds a sharer, update miss inserts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (ctl_i.commit) begin
      if ((cmd_q == CMD_UPDATE) && !hit_q) begin
        if (!evict_q) begin
          occ_q <= occ_q + OCC_W'(1);
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_q[i]) begin
            valid_q[i] <= 1'b1;
            rank_q[i]  <= '0;
          end else if (valid_q[i]) begin
            rank_q[i] <= rank_q[i] + RANK_W'(1);
          end
        end
      end else if ((cmd_q == CMD_LOOKUP) && hit_q) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (match_q[i]) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < frank_q)) begin
            rank_q[i] <= rank_q[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit && (cmd_q == CMD_UPDATE)) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (hit_q && match_q[i]) begin
          sharer_q[i] <= sharer_q[i] | ubit;
        end else if (!hit_q && slot_q[i]) begin
          tag_q[i]    <= page_q;
          sharer_q[i] <= ubit;
        end
      end
    end
  end

  assign hit_o         = hit_q;
  assign sharer_mask_o = mask_q;
  assign evicted_o     = evict_q;

endmodule
`default_nettype wire

### rtl/lpsd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpsd_checker
// Port-level checks of the page sharer directory, bound to the top level.
// ----------------------------------------------------------------------------
module lpsd_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            busy,
  input  wire logic                            done_o,
  input  wire logic                            hit_o,
  input  wire logic [lpsd_pkg::NUM_UNITS-1:0]  sharer_mask_o,
  input  wire logic                            evicted_o
);
  import lpsd_pkg::*;

  // Every compare cycle retires into a result on the next cycle.
  a_busy_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o)
    else $error("compare cycle not followed by a result");

  // A result only ever follows a compare cycle.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a preceding compare");

  // Results and compares never overlap.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_o && busy))
    else $error("result shown while busy");

  // An eviction only comes from a miss.
  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_o) |-> !hit_o)
    else $error("eviction reported on a hit");

  // A forwarded mask only comes with a hit, never with an eviction.
  a_mask_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (sharer_mask_o != '0)) |-> (hit_o && !evicted_o))
    else $error("sharer mask without a lookup hit");

endmodule

bind lru_page_sharer_directory lpsd_checker u_lpsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .busy          (busy),
  .done_o        (done_o),
  .hit_o         (hit_o),
  .sharer_mask_o (sharer_mask_o),
  .evicted_o     (evicted_o)
);
`default_nettype wire

### bench/lpsd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpsd_tb_checker
// Watches the request, configuration and result ports of the page sharer
// directory. It keeps its own copy of the LRU table, forecasts each reply
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module lpsd_tb_checker
  import lpsd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic                 cmd_i,
  input  wire logic [ADDR_W-1:0]    virt_addr_i,
  input  wire logic [CU_W-1:0]      cu_index_i,
  input  wire logic                 done_o,
  input  wire logic                 hit_o,
  input  wire logic [NUM_UNITS-1:0] sharer_mask_o,
  input  wire logic                 evicted_o,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic                 hit;
    logic [NUM_UNITS-1:0] sharers;
    logic                 evicted;
  } dir_reply_t;

  logic [TAG_W-1:0]     tag_mem    [MAX_ENTRIES];
  logic                 entry_live [MAX_ENTRIES];
  logic [NUM_UNITS-1:0] share_mem  [MAX_ENTRIES];
  logic [RANK_W-1:0]    age        [MAX_ENTRIES];
  logic [CFG_W-1:0]     size_reg;
  dir_reply_t           pending_replies [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  // Apply one request to the shadow table and return the reply it causes.
  function automatic dir_reply_t apply_request(input lpsd_cmd_e cmd,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [CU_W-1:0] cu);
    logic [TAG_W-1:0]     page;
    logic [NUM_UNITS-1:0] unit_mask;
    logic [RANK_W-1:0]    worst;
    logic [RANK_W-1:0]    old_age;
    int                   found;
    int                   slot;
    int                   occupied;
    int                   cap;
    dir_reply_t           r;
    page      = addr[ADDR_W-1:PAGE_SHIFT];
    unit_mask = (int'(cu) < NUM_UNITS) ? (NUM_UNITS'(1) << cu) : '0;
    r         = '0;
    found     = -1;
    slot      = -1;
    occupied  = 0;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (found < 0 && entry_live[i] && tag_mem[i] == page) found = i;
    if (cmd == CMD_LOOKUP) begin
      if (found >= 0) begin
        // Promote to MRU: entries younger than it age by one.
        r.hit     = 1'b1;
        r.sharers = share_mem[found];
        old_age   = age[found];
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (entry_live[i] && i != found && age[i] < old_age) age[i]++;
        age[found] = '0;
      end
    end else if (found >= 0) begin
      r.hit = 1'b1;
      share_mem[found] |= unit_mask;
    end else begin
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (entry_live[i]) occupied++;
      cap = (size_reg == '0) ? 1 :
            (int'(size_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(size_reg);
      if (occupied >= cap) begin
        worst = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (entry_live[i] && (slot < 0 || age[i] > worst)) begin
            slot  = i;
            worst = age[i];
          end
        if (slot >= 0) begin
          entry_live[slot] = 1'b0;
          r.evicted        = 1'b1;
        end
      end else begin
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (slot < 0 && !entry_live[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (entry_live[i]) age[i]++;
        entry_live[slot] = 1'b1;
        tag_mem[slot]    = page;
        share_mem[slot]  = unit_mask;
        age[slot]        = '0;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dir_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entry_live[i] = 1'b0;
        age[i]        = '0;
      end
      size_reg = TABLE_SIZE_RST;
      pending_replies.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i === 1'b1) size_reg = cfg_wdata_i;
      // Retire a result before taking a new request on the same edge.
      if (done_o === 1'b1) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unrequested result", 32'(hit_o), 32'(0));
        end else begin
          want = pending_replies[0];
          pending_replies.delete(0);
          if (hit_o !== want.hit)
            report_mismatch("hit", 32'(hit_o), 32'(want.hit));
          if (sharer_mask_o !== want.sharers)
            report_mismatch("sharer_mask", 32'(sharer_mask_o), 32'(want.sharers));
          if (evicted_o !== want.evicted)
            report_mismatch("evicted", 32'(evicted_o), 32'(want.evicted));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        pending_replies.insert(pending_replies.size(),
                               apply_request(lpsd_cmd_e'(cmd_i), virt_addr_i,
                                             cu_index_i));
      pending_o = pending_replies.size();
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the page sharer directory. A directed sequence
// walks through hits, misses, evictions and the table size corner cases,
// then random phases run over a small pool of pages per table size so that
// hits, promotions and LRU evictions happen all the time. The checker beside
// the block forecasts and compares every reply.
// ----------------------------------------------------------------------------
module tb_top;
  import lpsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int POOL_MAX       = 48;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 138;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 start;
  logic                 busy;
  logic                 cmd_i;
  logic [ADDR_W-1:0]    virt_addr_i;
  logic [CU_W-1:0]      cu_index_i;
  logic                 done_o;
  logic                 hit_o;
  logic [NUM_UNITS-1:0] sharer_mask_o;
  logic                 evicted_o;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  // Pages that the random phases draw from; refilled for every table size.
  logic [TAG_W-1:0] page_pool [POOL_MAX];
  int               pool_depth;

  // Table sizes per random phase: zero and the out-of-range top value are
  // included, and the drop from a full table to one entry as well.
  logic [CFG_W-1:0] phase_sizes [NUM_PHASES] = '{
    6'd4, 6'd63, 6'd0, 6'd1, 6'd32, 6'd2, 6'd33, 6'd12, 6'd5, 6'd20
  };

  lru_page_sharer_directory dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .virt_addr_i  (virt_addr_i),
    .cu_index_i   (cu_index_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .sharer_mask_o(sharer_mask_o),
    .evicted_o    (evicted_o)
  );

  lpsd_tb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .virt_addr_i  (virt_addr_i),
    .cu_index_i   (cu_index_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .sharer_mask_o(sharer_mask_o),
    .evicted_o    (evicted_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: end the run if no transaction, result or register write
  // happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done_o === 1'b1 ||
        cfg_we_i === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request and hold it until the block takes it. Start stays
  // high on return so back-to-back requests need no extra edge.
  task automatic send_request(input lpsd_cmd_e cmd, input logic [ADDR_W-1:0] addr,
                              input logic [CU_W-1:0] cu);
    start       <= 1'b1;
    cmd_i       <= cmd;
    virt_addr_i <= addr;
    cu_index_i  <= cu;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Drop start for a number of cycles; a zero gap keeps the burst going.
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every forecast reply has come back, then
  // give the block a few cycles to settle.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Write table_size only once the block is idle.
  task automatic write_table_size(input logic [CFG_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Refill the page pool with about one and a half times the entries the
  // table holds, so hits and evictions both stay frequent.
  task automatic fill_pool(input logic [CFG_W-1:0] size);
    int cap;
    cap = (size == '0) ? 1 : (int'(size) > MAX_ENTRIES) ? MAX_ENTRIES : int'(size);
    pool_depth = cap + cap / 2 + 2;
    if (pool_depth > POOL_MAX) pool_depth = POOL_MAX;
    for (int i = 0; i < pool_depth; i++) page_pool[i] = TAG_W'({$urandom, $urandom});
  endtask

  // Mostly pool pages with a random in-page offset; the rest are wild
  // addresses that almost always miss.
  task automatic random_request();
    logic [ADDR_W-1:0] addr;
    lpsd_cmd_e         cmd;
    if ($urandom_range(0, 99) < 90)
      addr = {page_pool[$urandom_range(0, pool_depth - 1)], PAGE_SHIFT'($urandom)};
    else
      addr = ADDR_W'({$urandom, $urandom});
    cmd = ($urandom_range(0, 99) < 45) ? CMD_UPDATE : CMD_LOOKUP;
    send_request(cmd, addr, CU_W'($urandom));
  endtask

  initial begin
    int  burst;
    bit  no_gaps;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    start       <= 1'b0;
    cmd_i       <= CMD_LOOKUP;
    virt_addr_i <= '0;
    cu_index_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, default table size first.
    send_request(CMD_LOOKUP, ADDR_W'(0), CU_W'(0));              // empty table, miss
    send_request(CMD_UPDATE, ADDR_W'(0), CU_W'(0));              // insert page zero
    send_request(CMD_UPDATE, ADDR_W'('hFFF), CU_W'(15));         // same page, add unit 15
    send_request(CMD_LOOKUP, ADDR_W'('h123), CU_W'(9));          // hit with two sharers
    send_request(CMD_UPDATE, {ADDR_W{1'b1}}, CU_W'(15));         // topmost page
    send_request(CMD_LOOKUP, ADDR_W'('hFFFF_FFFF_F000), CU_W'(0));
    send_request(CMD_UPDATE, ADDR_W'('h1000), CU_W'(7));
    send_request(CMD_LOOKUP, ADDR_W'('h1FFF), CU_W'(0));
    send_request(CMD_LOOKUP, ADDR_W'('h2000), CU_W'(0));         // neighbor page, miss
    send_request(CMD_UPDATE, ADDR_W'('h1000), CU_W'(7));         // unit already a sharer
    send_request(CMD_UPDATE, ADDR_W'('hAAAA_AAAA_A000), CU_W'(10));
    send_request(CMD_UPDATE, ADDR_W'('h5555_5555_5000), CU_W'(5));
    send_request(CMD_LOOKUP, ADDR_W'(0), CU_W'(0));              // promote page zero
    hold_off(2);

    // Shrink the table below its occupancy: misses evict, nothing grows.
    write_table_size(6'd2);
    send_request(CMD_UPDATE, ADDR_W'('h3000), CU_W'(1));
    send_request(CMD_UPDATE, ADDR_W'('h4000), CU_W'(2));
    send_request(CMD_LOOKUP, ADDR_W'(0), CU_W'(0));
    send_request(CMD_LOOKUP, ADDR_W'('h3ABC), CU_W'(0));

    // Zero size acts as a single entry.
    write_table_size(6'd0);
    send_request(CMD_UPDATE, ADDR_W'('h5000), CU_W'(3));
    send_request(CMD_UPDATE, ADDR_W'('h5000), CU_W'(4));
    send_request(CMD_LOOKUP, ADDR_W'('h5FFF), CU_W'(0));

    // Oversize value acts as the full table.
    write_table_size(6'd63);
    send_request(CMD_UPDATE, ADDR_W'('h6000), CU_W'(0));
    send_request(CMD_UPDATE, ADDR_W'('h7000), CU_W'(15));
    send_request(CMD_LOOKUP, ADDR_W'('h5000), CU_W'(0));

    // Random phases: bursts with random gaps, some phases without gaps.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_table_size(phase_sizes[phase]);
      fill_pool(phase_sizes[phase]);
      no_gaps = ($urandom_range(0, 3) == 0);
      burst   = $urandom_range(1, 16);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_request();
        // Let the pipeline empty completely once in the middle of a phase.
        if (phase == 1 && n == PHASE_ITEMS / 2) begin
          drain();
        end else begin
          burst--;
          if (burst <= 0) begin
            burst = $urandom_range(1, 16);
            if (!no_gaps) hold_off($urandom_range(0, 5));
          end
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lpsd_pkg.sv
rtl/lpsd_ctrl.sv
rtl/lpsd_dp.sv
rtl/lru_page_sharer_directory.sv
rtl/lpsd_checker.sv
bench/lpsd_checker.sv
bench/tb_top.sv
